// ===== src/tpre_pkg.sv =====
// Shared types, constants and command codes of the tag pitch range estimator.
package tpre_pkg;

  localparam int MAX_TAGS_DEF = 32;

  localparam int ID_W    = 10;
  localparam int ROW_W   = 2;
  localparam int COL_W   = 5;
  localparam int PIX_W   = 16;
  localparam int TIME_W  = 32;
  localparam int RANGE_W = 14;
  localparam int MNT_W   = 14;
  localparam int POS_W   = 16;

  // Shared divider: dividend, divisor and quotient widths.
  localparam int DVD_W = 36;
  localparam int DVS_W = 18;
  localparam int QUO_W = 17;

  // Width of one kept pair estimate (at most 6000 mm).
  localparam int EST_W = 13;

  localparam int P1_W  = 23;
  localparam int NUM_W = 35;
  localparam int PRD_W = 30;
  localparam int YS_W  = 19;

  localparam logic [PIX_W-1:0] GAP_MIN_PX16 = 16'd160;
  localparam int RANGE_MIN_MM = 2000;
  localparam int RANGE_MAX_MM = 6000;

  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_LOAD   = 3'd1;
  localparam logic [2:0] CMD_DETECT = 3'd2;
  localparam logic [2:0] CMD_FRAME  = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;

  localparam logic [2:0] REG_DEFAULT_RANGE = 3'd0;
  localparam logic [2:0] REG_LOST_TIMEOUT  = 3'd1;
  localparam logic [2:0] REG_COLUMN_PITCH  = 3'd2;
  localparam logic [2:0] REG_FOCAL         = 3'd3;
  localparam logic [2:0] REG_CENTER        = 3'd4;
  localparam logic [2:0] REG_MOUNT_X       = 3'd5;
  localparam logic [2:0] REG_MOUNT_Y       = 3'd6;
  localparam logic [2:0] REG_MOUNT_Z       = 3'd7;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [PIX_W-1:0]  pix;
    logic [TIME_W-1:0] seen_time;
  } entry_t;

  typedef struct packed {
    logic [RANGE_W-1:0] default_range;
    logic [15:0]        timeout;
    logic [11:0]        pitch;
    logic [17:0]        focal;
    logic [15:0]        center;
    logic [MNT_W-1:0]   mount_x;
    logic [MNT_W-1:0]   mount_y;
    logic [MNT_W-1:0]   mount_z;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLEAR,
    OP_READ_I,
    OP_READ_J,
    OP_SEARCH,
    OP_WRITE,
    OP_TICK_INC,
    OP_TICK_EVAL,
    OP_FRESH_EVAL,
    OP_NEXT_I,
    OP_PAIR_I,
    OP_NEXT_J,
    OP_PAIR_J,
    OP_MUL1,
    OP_MUL2,
    OP_DIV_PAIR,
    OP_ACCUM,
    OP_DIV_AVG,
    OP_SET_RANGE,
    OP_EMIT_RANGE,
    OP_SEL_EVAL,
    OP_POS_MUL,
    OP_DIV_POS,
    OP_EMIT_POS
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic i_last;
    logic j_last;
    logic fresh_i;
    logic fresh_j;
    logic pair_ok;
    logic keep;
    logic div_done;
    logic none_seen;
    logic cnt_zero;
    logic focal_zero;
    logic emit_last;
  } dp_stat_t;

endpackage

// ===== src/tpre_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tpre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/tpre_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating on quotient overflow.
module tpre_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tpre_pkg::DVD_W-1:0] dividend,
  input  logic [tpre_pkg::DVS_W-1:0] divisor,
  output logic [tpre_pkg::QUO_W-1:0] quot,
  output logic                       done
);
  import tpre_pkg::*;

  localparam int STEP_W = $clog2(QUO_W + 1);

  logic [DVD_W-1:0]  rem_r;
  logic [DVD_W-1:0]  dsr_r;
  logic [QUO_W-1:0]  q_r;
  logic [STEP_W-1:0] step_r;
  logic              run_r;
  logic              done_r;
  logic              ovf_r;
  logic [DVD_W-1:0]  lim_c;

  // divisor scaled to the first quotient bit past the top
  assign lim_c = DVD_W'(divisor) << QUO_W;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && step_r == STEP_W'(QUO_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      dsr_r  <= DVD_W'(divisor) << (QUO_W - 1);
      q_r    <= '0;
      step_r <= '0;
      ovf_r  <= dividend >= lim_c;
    end else if (run_r) begin
      if (rem_r >= dsr_r) begin
        rem_r <= rem_r - dsr_r;
        q_r   <= {q_r[QUO_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QUO_W-2:0], 1'b0};
      end
      dsr_r  <= dsr_r >> 1;
      step_r <= step_r + 1'b1;
    end
  end

  assign quot = ovf_r ? '1 : q_r;
  assign done = done_r;

endmodule

// ===== src/tpre_dp.sv =====
// Datapath: tag table, tick clock, pair estimator arithmetic and result registers.
module tpre_dp #(
  parameter int MAX_TAGS = tpre_pkg::MAX_TAGS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tpre_pkg::dp_cmd_t            cmd,
  input  tpre_pkg::cfg_t               cfg,
  input  logic [2:0]                   in_command,
  input  logic [tpre_pkg::ID_W-1:0]    in_tag_id,
  input  logic [tpre_pkg::ROW_W-1:0]   in_tag_row,
  input  logic [tpre_pkg::COL_W-1:0]   in_tag_col,
  input  logic [tpre_pkg::PIX_W-1:0]   in_pixel_col,
  output tpre_pkg::dp_stat_t           stat,
  output logic                         out_valid,
  output logic                         out_kind,
  output logic [tpre_pkg::ID_W-1:0]    out_tag_id,
  output logic [tpre_pkg::ROW_W-1:0]   out_row,
  output logic [tpre_pkg::COL_W-1:0]   out_col,
  output logic signed [tpre_pkg::POS_W-1:0] out_pos_x_mm,
  output logic signed [tpre_pkg::POS_W-1:0] out_pos_y_mm,
  output logic signed [tpre_pkg::MNT_W-1:0] out_pos_z_mm,
  output logic [tpre_pkg::RANGE_W-1:0] out_range_mm,
  output logic                         out_last
);
  import tpre_pkg::*;

  localparam int IDX_W  = $clog2(MAX_TAGS);
  localparam int CNTS_W = $clog2(MAX_TAGS + 1);
  localparam int NPAIR  = MAX_TAGS * (MAX_TAGS - 1) / 2;
  localparam int PCNT_W = $clog2(NPAIR + 1);
  localparam int SUM_W  = PCNT_W + EST_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TAGS - 1);

  dp_op_t op;
  assign op = cmd.op;

  // control state
  logic [TIME_W-1:0]   now_r;
  logic [MAX_TAGS-1:0] valid_r;
  logic [MAX_TAGS-1:0] seen_r;
  logic                out_valid_r;

  // working registers
  logic [2:0]         cmd_r;
  logic [ID_W-1:0]    id_r;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic [PIX_W-1:0]   pix_r;
  logic [MAX_TAGS-1:0] fresh_r;
  logic [IDX_W-1:0]   i_r;
  logic [IDX_W-1:0]   j_r;
  logic [IDX_W-1:0]   slot_r;
  logic [IDX_W-1:0]   free_slot_r;
  logic               found_r;
  logic               free_r;
  entry_t             word_r;
  logic [ROW_W-1:0]   rowi_r;
  logic [COL_W-1:0]   coli_r;
  logic [PIX_W-1:0]   pixi_r;
  logic [COL_W-1:0]   dc_r;
  logic [PIX_W-1:0]   gap_r;
  logic [P1_W-1:0]    p1_r;
  logic [NUM_W-1:0]   num_r;
  logic [SUM_W-1:0]   sum_r;
  logic [PCNT_W-1:0]  pcnt_r;
  logic [CNTS_W-1:0]  seen_cnt_r;
  logic [CNTS_W-1:0]  emit_cnt_r;
  logic [RANGE_W-1:0] range_r;
  logic               have_prev_r;
  logic [ID_W-1:0]    prev_id_r;
  logic               best_f_r;
  logic               neg_r;
  logic [PRD_W-1:0]   prod_r;

  logic                      out_kind_r;
  logic [ID_W-1:0]           out_id_r;
  logic [ROW_W-1:0]          out_row_r;
  logic [COL_W-1:0]          out_col_r;
  logic signed [POS_W-1:0]   out_x_r;
  logic signed [POS_W-1:0]   out_y_r;
  logic signed [MNT_W-1:0]   out_z_r;
  logic [RANGE_W-1:0]        out_range_r;
  logic                      out_last_r;

  // table memory
  entry_t     rd_c;
  entry_t     wword_c;
  logic       we_c;
  logic       re_c;
  logic [IDX_W-1:0] raddr_c;
  logic [IDX_W-1:0] wslot_c;
  logic       load_c;
  logic       wr_ok_c;

  assign load_c  = cmd_r == CMD_LOAD;
  assign wslot_c = found_r ? slot_r : free_slot_r;
  assign wr_ok_c = load_c ? (found_r | free_r) : found_r;
  assign we_c    = op == OP_WRITE && wr_ok_c;
  assign re_c    = op == OP_READ_I || op == OP_READ_J;
  assign raddr_c = (op == OP_READ_J) ? j_r : i_r;

  always_comb begin
    if (load_c) begin
      wword_c = '{id: id_r, row: row_r, col: col_r, pix: pix_r, seen_time: now_r};
    end else begin
      wword_c = '{id: word_r.id, row: word_r.row, col: word_r.col, pix: pix_r,
                  seen_time: now_r};
    end
  end

  tpre_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_TAGS)
  ) u_table (
    .clk   (clk),
    .we    (we_c),
    .waddr (wslot_c),
    .wdata (wword_c),
    .re    (re_c),
    .raddr (raddr_c),
    .rdata (rd_c)
  );

  // shared divider
  logic             div_start_c;
  logic [DVD_W-1:0] div_dvd_c;
  logic [DVS_W-1:0] div_dvs_c;
  logic [QUO_W-1:0] div_quot;
  logic             div_done;

  always_comb begin
    div_start_c = 1'b0;
    div_dvd_c   = DVD_W'(num_r);
    div_dvs_c   = DVS_W'(gap_r);
    case (op)
      OP_DIV_PAIR: begin
        div_start_c = 1'b1;
      end
      OP_DIV_AVG: begin
        div_start_c = 1'b1;
        div_dvd_c   = DVD_W'(sum_r);
        div_dvs_c   = DVS_W'(pcnt_r);
      end
      OP_DIV_POS: begin
        div_start_c = 1'b1;
        div_dvd_c   = DVD_W'(prod_r);
        div_dvs_c   = cfg.focal;
      end
      default: begin
        div_start_c = 1'b0;
      end
    endcase
  end

  tpre_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_c),
    .dividend (div_dvd_c),
    .divisor  (div_dvs_c),
    .quot     (div_quot),
    .done     (div_done)
  );

  // per-entry evaluation
  logic [TIME_W-1:0] age_c;
  logic              stale_c;
  logic              vs_c;
  logic              match_c;
  logic [COL_W-1:0]  dc_c;
  logic [PIX_W-1:0]  gap_c;
  logic              better_c;
  logic [IDX_W-1:0]  i_inc_c;

  assign age_c   = now_r - rd_c.seen_time;
  assign stale_c = age_c > TIME_W'(cfg.timeout);
  assign vs_c    = valid_r[i_r] & seen_r[i_r];
  assign match_c = valid_r[i_r] && rd_c.id == id_r;
  assign dc_c    = (rd_c.col > coli_r) ? rd_c.col - coli_r : coli_r - rd_c.col;
  assign gap_c   = (rd_c.pix > pixi_r) ? rd_c.pix - pixi_r : pixi_r - rd_c.pix;
  assign better_c = vs_c && (!have_prev_r || rd_c.id > prev_id_r) &&
                    (!best_f_r || rd_c.id < word_r.id);
  assign i_inc_c = (i_r == IDX_LAST) ? '0 : i_r + 1'b1;

  logic [NUM_W-1:0] lo_c;
  logic [NUM_W-1:0] hi_c;
  assign lo_c = NUM_W'(gap_r) * NUM_W'(RANGE_MIN_MM);
  assign hi_c = NUM_W'(gap_r) * NUM_W'(RANGE_MAX_MM);

  // lateral position
  logic [PIX_W:0]           d_c;
  logic [PIX_W:0]           dmag_c;
  logic [QUO_W-1:0]         qy_c;
  logic signed [YS_W-1:0]   qs_c;
  logic signed [YS_W-1:0]   ysum_c;
  logic signed [POS_W-1:0]  ysat_c;
  logic signed [POS_W-1:0]  x_c;

  assign d_c    = {1'b0, cfg.center} - {1'b0, word_r.pix};
  assign dmag_c = d_c[PIX_W] ? (~d_c + 1'b1) : d_c;
  assign qy_c   = (cfg.focal == '0) ? '0 : div_quot;
  assign qs_c   = neg_r ? -$signed({2'b00, qy_c}) : $signed({2'b00, qy_c});
  assign ysum_c = $signed({{(YS_W-MNT_W){cfg.mount_y[MNT_W-1]}}, cfg.mount_y}) + qs_c;

  always_comb begin
    if (ysum_c > YS_W'(32767)) begin
      ysat_c = 16'sh7FFF;
    end else if (ysum_c < -YS_W'(32768)) begin
      ysat_c = -16'sh8000;
    end else begin
      ysat_c = ysum_c[POS_W-1:0];
    end
  end

  assign x_c = $signed({{(POS_W-MNT_W){cfg.mount_x[MNT_W-1]}}, cfg.mount_x}) -
               $signed({2'b00, range_r});

  // control state: table flags, tick clock, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      valid_r     <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= op == OP_EMIT_RANGE || op == OP_EMIT_POS;
      case (op)
        OP_CLEAR: begin
          valid_r <= '0;
          seen_r  <= '0;
        end
        OP_WRITE: begin
          if (wr_ok_c) begin
            valid_r[wslot_c] <= 1'b1;
            seen_r[wslot_c]  <= !load_c;
          end
        end
        OP_TICK_INC: begin
          now_r <= now_r + 1'b1;
        end
        OP_TICK_EVAL: begin
          if (vs_c && stale_c) begin
            seen_r[i_r] <= 1'b0;
          end
        end
        default: begin
          now_r <= now_r;
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        cmd_r       <= in_command;
        id_r        <= in_tag_id;
        row_r       <= in_tag_row;
        col_r       <= in_tag_col;
        pix_r       <= in_pixel_col;
        i_r         <= '0;
        found_r     <= 1'b0;
        free_r      <= 1'b0;
        seen_cnt_r  <= '0;
        emit_cnt_r  <= '0;
        sum_r       <= '0;
        pcnt_r      <= '0;
        have_prev_r <= 1'b0;
        best_f_r    <= 1'b0;
      end
      OP_SEARCH: begin
        if (match_c && !found_r) begin
          found_r <= 1'b1;
          slot_r  <= i_r;
          word_r  <= rd_c;
        end
        if (!valid_r[i_r] && !free_r) begin
          free_r      <= 1'b1;
          free_slot_r <= i_r;
        end
        i_r <= i_inc_c;
      end
      OP_TICK_EVAL: begin
        i_r <= i_inc_c;
      end
      OP_FRESH_EVAL: begin
        fresh_r[i_r] <= vs_c && rd_c.row <= 2'd2 && !stale_c;
        seen_cnt_r   <= seen_cnt_r + CNTS_W'(vs_c);
        i_r          <= i_inc_c;
      end
      OP_NEXT_I: begin
        i_r <= i_inc_c;
      end
      OP_PAIR_I: begin
        rowi_r <= rd_c.row;
        coli_r <= rd_c.col;
        pixi_r <= rd_c.pix;
        j_r    <= i_r + 1'b1;
      end
      OP_NEXT_J: begin
        j_r <= j_r + 1'b1;
      end
      OP_PAIR_J: begin
        dc_r  <= dc_c;
        gap_r <= gap_c;
      end
      OP_MUL1: begin
        p1_r <= P1_W'(cfg.focal) * P1_W'(dc_r);
      end
      OP_MUL2: begin
        num_r <= NUM_W'(p1_r) * NUM_W'(cfg.pitch);
      end
      OP_ACCUM: begin
        sum_r  <= sum_r + SUM_W'(div_quot[EST_W-1:0]);
        pcnt_r <= pcnt_r + 1'b1;
      end
      OP_SET_RANGE: begin
        range_r <= (pcnt_r == '0) ? cfg.default_range : div_quot[RANGE_W-1:0];
      end
      OP_EMIT_RANGE: begin
        i_r         <= '0;
        out_kind_r  <= 1'b0;
        out_id_r    <= '0;
        out_row_r   <= '0;
        out_col_r   <= '0;
        out_x_r     <= '0;
        out_y_r     <= '0;
        out_z_r     <= '0;
        out_range_r <= range_r;
        out_last_r  <= seen_cnt_r == '0;
      end
      OP_SEL_EVAL: begin
        if (better_c) begin
          best_f_r <= 1'b1;
          word_r   <= rd_c;
        end
        i_r <= i_inc_c;
      end
      OP_POS_MUL: begin
        neg_r  <= d_c[PIX_W];
        prod_r <= PRD_W'(dmag_c[PIX_W-1:0]) * PRD_W'(range_r);
      end
      OP_EMIT_POS: begin
        out_kind_r  <= 1'b1;
        out_id_r    <= word_r.id;
        out_row_r   <= word_r.row;
        out_col_r   <= word_r.col;
        out_x_r     <= x_c;
        out_y_r     <= ysat_c;
        out_z_r     <= $signed(cfg.mount_z);
        out_range_r <= range_r;
        out_last_r  <= stat.emit_last;
        emit_cnt_r  <= emit_cnt_r + 1'b1;
        prev_id_r   <= word_r.id;
        have_prev_r <= 1'b1;
        best_f_r    <= 1'b0;
        i_r         <= '0;
      end
      default: begin
        cmd_r <= cmd_r;
      end
    endcase
  end

  always_comb begin
    stat.i_last     = i_r == IDX_LAST;
    stat.j_last     = j_r == IDX_LAST;
    stat.fresh_i    = fresh_r[i_r];
    stat.fresh_j    = fresh_r[j_r];
    stat.pair_ok    = rd_c.row == rowi_r && dc_c != '0 && gap_c > GAP_MIN_PX16;
    stat.keep       = num_r >= lo_c && num_r <= hi_c;
    stat.div_done   = div_done;
    stat.none_seen  = seen_cnt_r == '0;
    stat.cnt_zero   = pcnt_r == '0;
    stat.focal_zero = cfg.focal == '0;
    stat.emit_last  = CNTS_W'(emit_cnt_r + 1'b1) == seen_cnt_r;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_tag_id   = out_id_r;
  assign out_row      = out_row_r;
  assign out_col      = out_col_r;
  assign out_pos_x_mm = out_x_r;
  assign out_pos_y_mm = out_y_r;
  assign out_pos_z_mm = out_z_r;
  assign out_range_mm = out_range_r;
  assign out_last     = out_last_r;

endmodule

// ===== src/tpre_ctrl.sv =====
// Controller: sequences table scans, pair estimation and result emission.
module tpre_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2:0]         in_command,
  input  tpre_pkg::dp_stat_t stat,
  output tpre_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import tpre_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR,
    S_SR_RD, S_SR_EV, S_SR_WR,
    S_TK_INC, S_TK_RD, S_TK_EV,
    S_FR_RD, S_FR_EV,
    S_PI_CHK, S_PI_EV, S_PJ_CHK, S_PJ_EV, S_NEXT,
    S_MUL1, S_MUL2, S_CMP, S_PDIV, S_ACC,
    S_AVG, S_ADIV, S_EMR,
    S_SL_RD, S_SL_EV, S_PMUL, S_PDIVY, S_PWAIT, S_EMP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  dp_op_t op_c;

  always_comb begin
    state_nxt = state_r;
    op_c      = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_c = OP_LATCH;
          case (in_command)
            CMD_CLEAR:  state_nxt = S_CLEAR;
            CMD_LOAD:   state_nxt = S_SR_RD;
            CMD_DETECT: state_nxt = S_SR_RD;
            CMD_FRAME:  state_nxt = S_FR_RD;
            CMD_TICK:   state_nxt = S_TK_INC;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        op_c      = OP_CLEAR;
        state_nxt = S_IDLE;
      end
      S_SR_RD: begin
        op_c      = OP_READ_I;
        state_nxt = S_SR_EV;
      end
      S_SR_EV: begin
        op_c      = OP_SEARCH;
        state_nxt = stat.i_last ? S_SR_WR : S_SR_RD;
      end
      S_SR_WR: begin
        op_c      = OP_WRITE;
        state_nxt = S_IDLE;
      end
      S_TK_INC: begin
        op_c      = OP_TICK_INC;
        state_nxt = S_TK_RD;
      end
      S_TK_RD: begin
        op_c      = OP_READ_I;
        state_nxt = S_TK_EV;
      end
      S_TK_EV: begin
        op_c      = OP_TICK_EVAL;
        state_nxt = stat.i_last ? S_IDLE : S_TK_RD;
      end
      S_FR_RD: begin
        op_c      = OP_READ_I;
        state_nxt = S_FR_EV;
      end
      S_FR_EV: begin
        op_c      = OP_FRESH_EVAL;
        state_nxt = stat.i_last ? S_PI_CHK : S_FR_RD;
      end
      S_PI_CHK: begin
        if (stat.i_last) begin
          state_nxt = S_AVG;
        end else if (stat.fresh_i) begin
          op_c      = OP_READ_I;
          state_nxt = S_PI_EV;
        end else begin
          op_c = OP_NEXT_I;
        end
      end
      S_PI_EV: begin
        op_c      = OP_PAIR_I;
        state_nxt = S_PJ_CHK;
      end
      S_PJ_CHK: begin
        if (stat.fresh_j) begin
          op_c      = OP_READ_J;
          state_nxt = S_PJ_EV;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_PJ_EV: begin
        op_c      = OP_PAIR_J;
        state_nxt = stat.pair_ok ? S_MUL1 : S_NEXT;
      end
      S_NEXT: begin
        if (stat.j_last) begin
          op_c      = OP_NEXT_I;
          state_nxt = S_PI_CHK;
        end else begin
          op_c      = OP_NEXT_J;
          state_nxt = S_PJ_CHK;
        end
      end
      S_MUL1: begin
        op_c      = OP_MUL1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        op_c      = OP_MUL2;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (stat.keep) begin
          op_c      = OP_DIV_PAIR;
          state_nxt = S_PDIV;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_PDIV: begin
        if (stat.div_done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        op_c      = OP_ACCUM;
        state_nxt = S_NEXT;
      end
      S_AVG: begin
        if (stat.cnt_zero) begin
          op_c      = OP_SET_RANGE;
          state_nxt = S_EMR;
        end else begin
          op_c      = OP_DIV_AVG;
          state_nxt = S_ADIV;
        end
      end
      S_ADIV: begin
        if (stat.div_done) begin
          op_c      = OP_SET_RANGE;
          state_nxt = S_EMR;
        end
      end
      S_EMR: begin
        op_c      = OP_EMIT_RANGE;
        state_nxt = stat.none_seen ? S_IDLE : S_SL_RD;
      end
      S_SL_RD: begin
        op_c      = OP_READ_I;
        state_nxt = S_SL_EV;
      end
      S_SL_EV: begin
        op_c      = OP_SEL_EVAL;
        state_nxt = stat.i_last ? S_PMUL : S_SL_RD;
      end
      S_PMUL: begin
        op_c      = OP_POS_MUL;
        state_nxt = S_PDIVY;
      end
      S_PDIVY: begin
        if (stat.focal_zero) begin
          state_nxt = S_EMP;
        end else begin
          op_c      = OP_DIV_POS;
          state_nxt = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (stat.div_done) begin
          state_nxt = S_EMP;
        end
      end
      S_EMP: begin
        op_c      = OP_EMIT_POS;
        state_nxt = stat.emit_last ? S_IDLE : S_SL_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.op = op_c;
  assign busy   = state_r != S_IDLE;

endmodule

// ===== src/tag_pitch_range_estimator.sv =====
// Top level of the tag pitch range estimator: register port, controller and datapath.
// Per item: clear empties the table; load and detection search it, then write; tick advances
// the clock and scans for stale tags. End of frame: a fresh pass, a gap test per fresh tag pair,
//   a range test and, when kept, a divide; the average; a selection scan per seen tag.
// One item at a time; results leave one per strobe and cannot be stalled. Reset (synchronous,
//   active low) empties the table, zeroes the tick clock and loads register defaults.
module tag_pitch_range_estimator #(
  parameter int MAX_TAGS = tpre_pkg::MAX_TAGS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_command,
  input  logic [tpre_pkg::ID_W-1:0]    in_tag_id,
  input  logic [tpre_pkg::ROW_W-1:0]   in_tag_row,
  input  logic [tpre_pkg::COL_W-1:0]   in_tag_col,
  input  logic [tpre_pkg::PIX_W-1:0]   in_pixel_col,
  output logic                         out_valid,
  output logic                         out_kind,
  output logic [tpre_pkg::ID_W-1:0]    out_tag_id,
  output logic [tpre_pkg::ROW_W-1:0]   out_row,
  output logic [tpre_pkg::COL_W-1:0]   out_col,
  output logic signed [tpre_pkg::POS_W-1:0] out_pos_x_mm,
  output logic signed [tpre_pkg::POS_W-1:0] out_pos_y_mm,
  output logic signed [tpre_pkg::MNT_W-1:0] out_pos_z_mm,
  output logic [tpre_pkg::RANGE_W-1:0] out_range_mm,
  output logic                         out_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tpre_pkg::*;

  cfg_t       cfg_r;
  logic       cfg_we_c;
  logic [2:0] cfg_idx_c;
  dp_cmd_t    dp_cmd;
  dp_stat_t   dp_stat;

  // register index is the word address; byte lanes below it are ignored
  assign cfg_idx_c = paddr[4:2];
  assign cfg_we_c  = psel & penable & pwrite;
  assign pready    = 1'b1;

  // hold register values; update only on a completed write access
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.default_range <= 14'd3000;
      cfg_r.timeout       <= 16'd50;
      cfg_r.pitch         <= 12'd500;
      cfg_r.focal         <= 18'd16384;
      cfg_r.center        <= 16'd10240;
      cfg_r.mount_x       <= '0;
      cfg_r.mount_y       <= '0;
      cfg_r.mount_z       <= '0;
    end else if (cfg_we_c) begin
      case (cfg_idx_c)
        REG_DEFAULT_RANGE: cfg_r.default_range <= pwdata[RANGE_W-1:0];
        REG_LOST_TIMEOUT:  cfg_r.timeout       <= pwdata[15:0];
        REG_COLUMN_PITCH:  cfg_r.pitch         <= pwdata[11:0];
        REG_FOCAL:         cfg_r.focal         <= pwdata[17:0];
        REG_CENTER:        cfg_r.center        <= pwdata[15:0];
        REG_MOUNT_X:       cfg_r.mount_x       <= pwdata[MNT_W-1:0];
        REG_MOUNT_Y:       cfg_r.mount_y       <= pwdata[MNT_W-1:0];
        REG_MOUNT_Z:       cfg_r.mount_z       <= pwdata[MNT_W-1:0];
        default:           cfg_r.pitch         <= cfg_r.pitch;
      endcase
    end
  end

  // read back the stored value, zero-extended to the bus
  always_comb begin
    case (cfg_idx_c)
      REG_DEFAULT_RANGE: prdata = 32'(cfg_r.default_range);
      REG_LOST_TIMEOUT:  prdata = 32'(cfg_r.timeout);
      REG_COLUMN_PITCH:  prdata = 32'(cfg_r.pitch);
      REG_FOCAL:         prdata = 32'(cfg_r.focal);
      REG_CENTER:        prdata = 32'(cfg_r.center);
      REG_MOUNT_X:       prdata = 32'(cfg_r.mount_x);
      REG_MOUNT_Y:       prdata = 32'(cfg_r.mount_y);
      REG_MOUNT_Z:       prdata = 32'(cfg_r.mount_z);
      default:           prdata = '0;
    endcase
  end

  // controller: accepts an item when idle and steps the datapath through it
  tpre_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (dp_stat),
    .cmd        (dp_cmd),
    .busy       (busy)
  );

  // datapath: table memory, clock, estimator arithmetic and result registers
  tpre_dp #(
    .MAX_TAGS (MAX_TAGS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (dp_cmd),
    .cfg          (cfg_r),
    .in_command   (in_command),
    .in_tag_id    (in_tag_id),
    .in_tag_row   (in_tag_row),
    .in_tag_col   (in_tag_col),
    .in_pixel_col (in_pixel_col),
    .stat         (dp_stat),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_tag_id   (out_tag_id),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_pos_x_mm (out_pos_x_mm),
    .out_pos_y_mm (out_pos_y_mm),
    .out_pos_z_mm (out_pos_z_mm),
    .out_range_mm (out_range_mm),
    .out_last     (out_last)
  );

endmodule
